[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the refinement indicator.
// Depends on nothing; each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SDRI_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("sdri assertion failed");
`define SDRI_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error("sdri forbidden condition");
`else
`define SDRI_ASSERT(lbl, prop)
`define SDRI_NEVER(lbl, expr)
`endif
`endif

[hdl/sdri_pkg.sv]
// Package for the second-derivative refinement indicator.
// Constants and defaults used by the top level; no dependencies.
`timescale 1ns / 1ps
package sdri_pkg;
	localparam int          DIMS_DEF        = 3;
	localparam int          SAMPLE_BITS_DEF = 32;
	localparam int          FIELD_BITS      = 32;
	localparam int          FRAC_BITS       = 16;
	localparam int          NORM_BITS       = 30;
	localparam int          QUO_BITS        = 32;
	localparam int          ROOT_STEPS      = QUO_BITS / 2 + 1;
	localparam logic [15:0] NOISE_RESET     = 16'd655;
	localparam logic [15:0] IND_MAX         = 16'hFFFF;

	typedef logic [NORM_BITS-1:0]     norm_t;
	typedef logic [2*NORM_BITS+1:0]   acc_t;
	typedef logic [QUO_BITS:0]        quo_t;
endpackage

[hdl/second_derivative_refinement_indicator_unit.sv]
// Second-derivative refinement indicator, fully pipelined.
// Depends on sdri_pkg and assert_macros.svh.
// Usage:
//   Input channel (in_valid/in_ready) carries one cell request: center value,
//   six axis neighbours and the domain-edge mask. Output channel
//   (out_valid/out_ready) returns indicator (Q0.16) and flat_region.
//   User writes noise_filter (cfg_we/cfg_wdata) only when idle; not enforced.
// Pipeline:
//   7 front stages (differences, denominators, max, leading-one search,
//   normalize, squares, sums), 32 restoring divider stages, 17 square-root
//   stages and the output register. Throughput is one request per cycle
//   unless the output stalls; every stage is a register.
// Reset:
//   arst_n clears all valid bits and loads noise_filter with 655 (~0.01).
// Stall:
//   When out_valid is high and out_ready low the whole pipeline holds and
//   in_ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module second_derivative_refinement_indicator_unit
	import sdri_pkg::*;
#(
	parameter int DIMS        = DIMS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] center_value,
	input  logic [31:0] x_minus_value,
	input  logic [31:0] x_plus_value,
	input  logic [31:0] y_minus_value,
	input  logic [31:0] y_plus_value,
	input  logic [31:0] z_minus_value,
	input  logic [31:0] z_plus_value,
	input  logic [5:0]  edge_mask,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] indicator,
	output logic        flat_region
);
	localparam int SW = SAMPLE_BITS;
	localparam int DW = SW + FRAC_BITS + 3;
	localparam int KW = $clog2(DW + 1);
	localparam int DIVS = QUO_BITS;
	localparam int AW = 2 * NORM_BITS + 2;

	// Helpers
	function automatic logic [SW-1:0] absd(input logic [SW-1:0] a, input logic [SW-1:0] b);
		logic [SW:0] t;
		logic [SW:0] n;
		t = {a[SW-1], a} - {b[SW-1], b};
		n = -t;
		return t[SW] ? n[SW-1:0] : t[SW-1:0];
	endfunction

	// Configuration register
	logic [15:0] noise_filter_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_filter_q <= NOISE_RESET;
		end else if (cfg_we) begin
			noise_filter_q <= cfg_wdata;
		end
	end

	// Pipeline advance: global hold on output stall
	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// Sample extension
	logic [31:0]    fld [0:6];
	logic [SW-1:0]  smp [0:6];
	assign fld[0] = center_value;
	assign fld[1] = x_minus_value;
	assign fld[2] = x_plus_value;
	assign fld[3] = y_minus_value;
	assign fld[4] = y_plus_value;
	assign fld[5] = z_minus_value;
	assign fld[6] = z_plus_value;
	for (genvar f = 0; f < 7; f++) begin : g_ext
		if (SW <= FIELD_BITS) begin : g_cut
			assign smp[f] = fld[f][SW-1:0];
		end else begin : g_sx
			assign smp[f] = {{(SW-FIELD_BITS){fld[f][31]}}, fld[f]};
		end
	end

	// Stage 1: one-sided differences, second difference, magnitudes
	logic              v_s1;
	logic [SW:0]       sabs_s1 [0:2];
	logic [SW+1:0]     mag_s1  [0:2];
	logic [SW+1:0]     d2_s1   [0:2];
	logic [SW:0]       sabs_c  [0:2];
	logic [SW+1:0]     mag_c   [0:2];
	logic [SW+1:0]     d2_c    [0:2];
	for (genvar a = 0; a < 3; a++) begin : g_ax
		if (a < DIMS) begin : g_on
			logic [SW-1:0] dpm, dmm, dpe, dme, cm, pm, mm;
			logic [SW+2:0] s2;
			logic [SW+2:0] s2n;
			logic          lo_e, hi_e;
			always_comb begin
				lo_e = edge_mask[2*a];
				hi_e = edge_mask[2*a+1];
				dpm  = absd(smp[2*a+2], smp[0]);
				dmm  = absd(smp[0], smp[2*a+1]);
				dme  = lo_e ? dpm : dmm;
				dpe  = hi_e ? dme : dpm;
				cm   = absd(smp[0], '0);
				pm   = absd(smp[2*a+2], '0);
				mm   = absd(smp[2*a+1], '0);
				s2   = {{3{smp[2*a+2][SW-1]}}, smp[2*a+2]}
				     + {{3{smp[2*a+1][SW-1]}}, smp[2*a+1]}
				     - {{2{smp[0][SW-1]}}, smp[0], 1'b0};
				s2n  = -s2;
				d2_c[a]   = (lo_e || hi_e) ? '0 : (s2[SW+2] ? s2n[SW+1:0] : s2[SW+1:0]);
				sabs_c[a] = {1'b0, dpe} + {1'b0, dme};
				mag_c[a]  = {1'b0, cm, 1'b0} + {2'b0, pm} + {2'b0, mm};
			end
		end else begin : g_off
			always_comb begin
				d2_c[a]   = '0;
				sabs_c[a] = '0;
				mag_c[a]  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sabs_s1 <= sabs_c;
			mag_s1  <= mag_c;
			d2_s1   <= d2_c;
		end
	end

	// Stage 2: denominators and numerators in Q.16 units
	logic          v_s2;
	logic [DW-1:0] den_s2 [0:2];
	logic [DW-1:0] num_s2 [0:2];
	logic [SW+17:0] mprod [0:2];
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			mprod[a] = mag_s1[a] * noise_filter_q;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				den_s2[a] <= DW'({sabs_s1[a], 16'b0}) + DW'(mprod[a]);
				num_s2[a] <= DW'({d2_s1[a], 16'b0});
			end
		end
	end

	// Stage 3: largest denominator and flat detect
	logic          v_s3, flat_s3;
	logic [DW-1:0] max_s3;
	logic [DW-1:0] den_s3 [0:2];
	logic [DW-1:0] num_s3 [0:2];
	logic [DW-1:0] max01;
	logic [DW-1:0] max_c;
	assign max01 = (den_s2[1] > den_s2[0]) ? den_s2[1] : den_s2[0];
	assign max_c = (den_s2[2] > max01) ? den_s2[2] : max01;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			max_s3  <= max_c;
			flat_s3 <= (max_c == '0);
			den_s3  <= den_s2;
			num_s3  <= num_s2;
		end
	end

	// Stage 4: leading-one search gives the normalizing shift
	logic          v_s4, flat_s4;
	logic [KW-1:0] k_s4;
	logic [DW-1:0] den_s4 [0:2];
	logic [DW-1:0] num_s4 [0:2];
	logic [KW-1:0] nbits;
	logic [KW-1:0] k_c;
	always_comb begin
		nbits = '0;
		for (int i = 0; i < DW; i++) begin
			if (max_s3[i]) nbits = KW'(i + 1);
		end
		k_c = (nbits > KW'(NORM_BITS)) ? nbits - KW'(NORM_BITS) : '0;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			k_s4    <= k_c;
			flat_s4 <= flat_s3;
			den_s4  <= den_s3;
			num_s4  <= num_s3;
		end
	end

	// Stage 5: common right shift
	logic          v_s5, flat_s5;
	norm_t         dn_s5 [0:2];
	norm_t         nn_s5 [0:2];
	logic [DW-1:0] dsh [0:2];
	logic [DW-1:0] nsh [0:2];
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			dsh[a] = den_s4[a] >> k_s4;
			nsh[a] = num_s4[a] >> k_s4;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			flat_s5 <= flat_s4;
			for (int a = 0; a < 3; a++) begin
				dn_s5[a] <= dsh[a][NORM_BITS-1:0];
				nn_s5[a] <= nsh[a][NORM_BITS-1:0];
			end
		end
	end

	// Stage 6: squares
	logic                   v_s6, flat_s6;
	logic [2*NORM_BITS-1:0] dq_s6 [0:2];
	logic [2*NORM_BITS-1:0] nq_s6 [0:2];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			flat_s6 <= flat_s5;
			for (int a = 0; a < 3; a++) begin
				dq_s6[a] <= dn_s5[a] * dn_s5[a];
				nq_s6[a] <= nn_s5[a] * nn_s5[a];
			end
		end
	end

	// Stage 7: sums and integer quotient bit
	acc_t  nsum, dsum;
	always_comb begin
		nsum = AW'(nq_s6[0]) + AW'(nq_s6[1]) + AW'(nq_s6[2]);
		dsum = AW'(dq_s6[0]) + AW'(dq_s6[1]) + AW'(dq_s6[2]);
	end

	// Divider pipeline: entry 0 is stage 7, one quotient bit per stage
	logic  dv_s  [0:DIVS];
	logic  df_s  [0:DIVS];
	acc_t  dr_s  [0:DIVS];
	acc_t  dd_s  [0:DIVS];
	quo_t  dq_s  [0:DIVS];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s[0] <= 1'b0;
		end else if (adv) begin
			dv_s[0] <= v_s6;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			df_s[0] <= flat_s6;
			dd_s[0] <= dsum;
			dr_s[0] <= (nsum >= dsum) ? nsum - dsum : nsum;
			dq_s[0] <= quo_t'(nsum >= dsum);
		end
	end
	for (genvar i = 1; i <= DIVS; i++) begin : g_div
		logic [AW:0] r2;
		logic [AW:0] rd;
		logic        ge;
		always_comb begin
			r2 = {dr_s[i-1], 1'b0};
			rd = r2 - {1'b0, dd_s[i-1]};
			ge = (r2 >= {1'b0, dd_s[i-1]});
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[i] <= 1'b0;
			end else if (adv) begin
				dv_s[i] <= dv_s[i-1];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				df_s[i] <= df_s[i-1];
				dd_s[i] <= dd_s[i-1];
				dr_s[i] <= ge ? rd[AW-1:0] : r2[AW-1:0];
				dq_s[i] <= {dq_s[i-1][QUO_BITS-1:0], ge};
			end
		end
	end

	// Square-root pipeline: one result bit per stage
	localparam int RTW = QUO_BITS + 2;
	logic           sv_s [0:ROOT_STEPS];
	logic           sf_s [0:ROOT_STEPS];
	logic [RTW-1:0] sx_s [0:ROOT_STEPS];
	logic [RTW-1:0] sr_s [0:ROOT_STEPS];
	always_comb begin
		sv_s[0] = dv_s[DIVS];
		sf_s[0] = df_s[DIVS];
		sx_s[0] = RTW'(dq_s[DIVS]);
		sr_s[0] = '0;
	end
	for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_sqrt
		localparam logic [RTW-1:0] BIT = RTW'(1) << (QUO_BITS - 2 * i);
		logic [RTW-1:0] t;
		assign t = sr_s[i] + BIT;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv_s[i+1] <= 1'b0;
			end else if (adv) begin
				sv_s[i+1] <= sv_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sf_s[i+1] <= sf_s[i];
				if (sx_s[i] >= t) begin
					sx_s[i+1] <= sx_s[i] - t;
					sr_s[i+1] <= (sr_s[i] >> 1) + BIT;
				end else begin
					sx_s[i+1] <= sx_s[i];
					sr_s[i+1] <= sr_s[i] >> 1;
				end
			end
		end
	end

	// Output register: saturate, force zero on flat region
	logic [RTW-1:0] root;
	assign root = sr_s[ROOT_STEPS];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= sv_s[ROOT_STEPS];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			flat_region <= sf_s[ROOT_STEPS];
			if (sf_s[ROOT_STEPS]) begin
				indicator <= '0;
			end else if (root[RTW-1:16] != '0) begin
				indicator <= IND_MAX;
			end else begin
				indicator <= root[15:0];
			end
		end
	end

	// Checks
	logic [DW-1:0] dtop_zero;
	assign dtop_zero = dsh[0] | dsh[1] | dsh[2];
	`SDRI_NEVER(a_norm_fits, v_s4 && (dtop_zero >> NORM_BITS) != '0)
	`SDRI_ASSERT(a_quo_range, (dv_s[DIVS] && !df_s[DIVS]) |-> (dq_s[DIVS] <= (quo_t'(1) << QUO_BITS)))
	`SDRI_ASSERT(a_root_range, (sv_s[ROOT_STEPS] && !sf_s[ROOT_STEPS]) |-> (root <= RTW'(65536)))
	`SDRI_ASSERT(a_flat_zero, (out_valid && flat_region) |-> (indicator == '0))
endmodule
